// ----- rtl/core/sumap_pkg.sv -----
// Package for the spectral upsample index map: sizes, field widths and the
// structs passed between the register file, the per-dimension mapper and the top.
// No dependencies.
`default_nettype none

package sumap_pkg;

   localparam int DIMS       = 3;
   localparam int NUM_AXES   = 3;
   localparam int MAX_SIZE   = 4096;
   localparam int SIZE_W     = 13;
   localparam int COORD_W    = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int HALV_W     = 2;

   localparam logic [SIZE_W-1:0] MAX_SIZE_V    = SIZE_W'(MAX_SIZE);
   localparam logic [SIZE_W-1:0] SRC_RESET_V   = SIZE_W'(64);
   localparam logic [SIZE_W-1:0] DST_RESET_V   = SIZE_W'(128);

   localparam logic [CSR_IDX_W-1:0] REG_SRC_SIZE_0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SRC_SIZE_1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SRC_SIZE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_DST_SIZE_0 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_DST_SIZE_1 = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_DST_SIZE_2 = CSR_IDX_W'(5);

   typedef struct packed {
      logic [SIZE_W-1:0] src_size;
      logic [SIZE_W-1:0] dst_size;
   } axis_cfg_type;

   typedef struct packed {
      logic               hit;
      logic               nyq;
      logic [COORD_W-1:0] idx;
   } axis_map_type;

endpackage

`default_nettype wire

// ----- rtl/core/sumap_csr.sv -----
// Size registers for the spectral upsample index map.
// Depends on sumap_pkg.
`default_nettype none

module sumap_csr
   import sumap_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_data,
   output axis_cfg_type              cfg [NUM_AXES]
);

   logic [SIZE_W-1:0] src_size_ff [NUM_AXES];
   logic [SIZE_W-1:0] dst_size_ff [NUM_AXES];
   logic [SIZE_W-1:0] wdata_in;
   logic              wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;
   assign wdata_in  = (csr_data > MAX_SIZE_V) ? MAX_SIZE_V : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_AXES; d++) begin
            src_size_ff[d] <= SRC_RESET_V;
            dst_size_ff[d] <= DST_RESET_V;
         end
      end else if (wr) begin
         unique case (csr_index)
            REG_SRC_SIZE_0: src_size_ff[0] <= wdata_in;
            REG_SRC_SIZE_1: src_size_ff[1] <= wdata_in;
            REG_SRC_SIZE_2: src_size_ff[2] <= wdata_in;
            REG_DST_SIZE_0: dst_size_ff[0] <= wdata_in;
            REG_DST_SIZE_1: dst_size_ff[1] <= wdata_in;
            REG_DST_SIZE_2: dst_size_ff[2] <= wdata_in;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int d = 0; d < NUM_AXES; d++) begin
         cfg[d].src_size = src_size_ff[d];
         cfg[d].dst_size = dst_size_ff[d];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sumap_axis.sv -----
// Classifies one target coordinate against one axis: low, Nyquist, high or outside.
// Depends on sumap_pkg.
`default_nettype none

module sumap_axis
   import sumap_pkg::*;
(
   input  wire logic [COORD_W-1:0] coord,
   input  wire axis_cfg_type       cfg,
   input  wire logic               full,
   input  wire logic               enable,
   output axis_map_type            map
);

   logic        [COORD_W-1:0]  half;
   logic signed [SIZE_W:0]     coord_s;
   logic signed [SIZE_W:0]     neg_s;
   logic        [SIZE_W:0]     high_src;
   logic                       is_low;
   logic                       is_pnyq;
   logic                       is_nnyq;
   logic                       is_high;

   assign half     = cfg.src_size[SIZE_W-1:1];
   assign coord_s  = $signed({2'b00, coord});
   assign neg_s    = $signed({1'b0, cfg.dst_size}) - $signed({2'b00, half});
   assign high_src = {2'b00, coord} - {1'b0, cfg.dst_size} + {1'b0, half, 1'b0};

   assign is_low  = coord < half;
   assign is_pnyq = coord == half;
   assign is_nnyq = full && (coord_s == neg_s);
   assign is_high = full && (coord_s > neg_s) && ({1'b0, coord} < cfg.dst_size);

   always_comb begin
      map = '{hit: 1'b0, nyq: 1'b0, idx: '0};
      priority if (!enable) begin
         map.hit = 1'b1;
      end else if (is_low) begin
         map.hit = 1'b1;
         map.idx = coord;
      end else if (is_pnyq || is_nnyq) begin
         map.hit = 1'b1;
         map.nyq = 1'b1;
         map.idx = half;
      end else if (is_high) begin
         map.hit = 1'b1;
         map.idx = high_src[COORD_W-1:0];
      end else begin
         map.hit = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/spectral_upsample_index_map.sv -----
// Top level of the spectral upsample index map: request register, per-axis
// classification, result register. Depends on sumap_pkg, sumap_csr, sumap_axis.
// A request moves from the request register into the result register once that one is free.
// Throughput: one request per cycle while results are taken; the result register frees as it is taken.
// Reset: synchronous, clears both valid flags and loads sizes 64 and 128.
`default_nettype none

module spectral_upsample_index_map
   import sumap_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [COORD_W-1:0]   req_dst_coord_0,
   input  wire logic [COORD_W-1:0]   req_dst_coord_1,
   input  wire logic [COORD_W-1:0]   req_dst_coord_2,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [COORD_W-1:0]        rsp_src_index_0,
   output logic [COORD_W-1:0]        rsp_src_index_1,
   output logic [COORD_W-1:0]        rsp_src_index_2,
   output logic                      rsp_is_zero,
   output logic [HALV_W-1:0]         rsp_halvings,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_data
);

   axis_cfg_type       cfg [NUM_AXES];
   axis_map_type       map [NUM_AXES];
   logic [COORD_W-1:0] coord_ff [NUM_AXES];
   logic [COORD_W-1:0] idx_ff [NUM_AXES];
   logic [COORD_W-1:0] idx_in [NUM_AXES];
   logic               req_vld_ff;
   logic               rsp_vld_ff;
   logic               zero_ff;
   logic               zero_in;
   logic [HALV_W-1:0]  halv_ff;
   logic [HALV_W-1:0]  halv_in;
   logic               rsp_free;
   logic               advance;
   logic               take;

   sumap_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   for (genvar d = 0; d < NUM_AXES; d++) begin : g_axis
      sumap_axis u_axis (
         .coord  (coord_ff[d]),
         .cfg    (cfg[d]),
         .full   (d < DIMS - 1),
         .enable (d < DIMS),
         .map    (map[d])
      );
   end

   assign rsp_free  = !rsp_vld_ff || rsp_ready;
   assign advance   = req_vld_ff && rsp_free;
   assign req_ready = !req_vld_ff || rsp_free;
   assign take      = req_valid && req_ready;

   always_comb begin
      zero_in = 1'b0;
      halv_in = '0;
      for (int d = 0; d < NUM_AXES; d++) begin
         zero_in = zero_in | !map[d].hit;
         halv_in = halv_in + HALV_W'(map[d].nyq);
      end
      for (int d = 0; d < NUM_AXES; d++) begin
         idx_in[d] = zero_in ? '0 : map[d].idx;
      end
      if (zero_in) begin
         halv_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_vld_ff <= req_valid;
         end
         if (rsp_free) begin
            rsp_vld_ff <= req_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         coord_ff[0] <= req_dst_coord_0;
         coord_ff[1] <= req_dst_coord_1;
         coord_ff[2] <= req_dst_coord_2;
      end
      if (advance) begin
         idx_ff  <= idx_in;
         zero_ff <= zero_in;
         halv_ff <= halv_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_src_index_0 = idx_ff[0];
   assign rsp_src_index_1 = idx_ff[1];
   assign rsp_src_index_2 = idx_ff[2];
   assign rsp_is_zero     = zero_ff;
   assign rsp_halvings    = halv_ff;

   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_zero |-> rsp_src_index_0 == '0 && rsp_src_index_1 == '0
         && rsp_src_index_2 == '0 && rsp_halvings == '0)
      else $error("zero result carries nonzero fields");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> req_vld_ff && rsp_valid && !rsp_ready)
      else $error("request stalled without a blocked result");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced request did not reach the result register");

   a_size_cap: assert property (@(posedge clock) disable iff (reset)
      cfg[0].src_size <= MAX_SIZE_V && cfg[1].src_size <= MAX_SIZE_V
         && cfg[2].src_size <= MAX_SIZE_V && cfg[0].dst_size <= MAX_SIZE_V
         && cfg[1].dst_size <= MAX_SIZE_V && cfg[2].dst_size <= MAX_SIZE_V)
      else $error("size register above maximum");

endmodule

`default_nettype wire
